[rtl/core/bpa_pkg.sv]
`timescale 1ns / 1ps
package bpa_pkg;

  // Pool geometry
  localparam int POOL_PAGES_LOG2 = 8;
  localparam int PAGE_SHIFT      = 12;
  localparam int PAGE_BYTES      = 1 << PAGE_SHIFT;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_IGNORED = 2'd2
  } res_status_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_INIT,
    DP_DECODE,
    DP_READ_Q,
    DP_SRCH_STEP,
    DP_FIND_STEP,
    DP_MARK,
    DP_MERGE_P,
    DP_MERGE_Q,
    DP_WALK_START,
    DP_SPLIT,
    DP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t      op;
    logic        res_en;
    res_status_t res_status;
    logic        set_exh;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free_op;
    logic bytes_zero;
    logic unit_zero;
    logic too_big;
    logic step_end;
    logic at_target;
    logic rd_free;
    logic merge_cand;
    logic merge_end;
    logic best_valid;
    logic split_more;
    logic changed;
  } dp_stat_t;

endpackage

[rtl/core/bpa_datapath.sv]
`timescale 1ns / 1ps
module bpa_datapath import bpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        in_op,
  input  logic [20:0] in_request_bytes,
  input  logic [8:0]  in_free_unit,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  output logic [1:0]  out_status,
  output logic [8:0]  out_data_unit,
  output logic        out_pool_exhausted
);

  // Header store: {exponent, free}
  logic [4:0]  mem_r [256];
  logic [4:0]  rd_data_r;
  logic        mem_we;
  logic [7:0]  mem_waddr;
  logic [4:0]  mem_wdata;
  logic [7:0]  rd_addr;

  logic [3:0]  pool_log2_r;
  logic        exh_r;
  logic        best_valid_r;
  logic        changed_r;

  logic        op_r;
  logic [20:0] bytes_r;
  logic [8:0]  unit_r;
  logic [3:0]  e_r;
  logic [8:0]  target_r;
  logic [8:0]  p_r;
  logic [8:0]  q_r;
  logic [3:0]  s_r;
  logic [8:0]  best_r;
  logic [3:0]  best_exp_r;
  res_status_t res_status_r;
  logic [8:0]  res_data_r;
  logic [1:0]  out_status_r;
  logic [8:0]  out_data_r;
  logic        out_exh_r;

  logic [3:0]  l_eff;
  logic [8:0]  n_pages;
  logic [3:0]  rd_exp;
  logic        rd_free;
  logic [9:0]  step_nxt;
  logic [9:0]  align_mask;
  logic        buddy;
  logic [9:0]  pair_nxt;
  logic [9:0]  mq_nxt;
  logic [21:0] round_sum;
  logic [10:0] pages;
  logic [3:0]  e_calc;
  logic        srch_hit;

  // Effective pool size, saturated to the legal range
  always_comb begin
    if (pool_log2_r == 4'd0) begin
      l_eff = 4'd1;
    end else if (pool_log2_r > 4'(POOL_PAGES_LOG2)) begin
      l_eff = 4'(POOL_PAGES_LOG2);
    end else begin
      l_eff = pool_log2_r;
    end
  end
  assign n_pages = 9'd1 << l_eff;

  assign rd_exp  = rd_data_r[4:1];
  assign rd_free = rd_data_r[0];

  // Walk arithmetic
  assign step_nxt   = {1'b0, p_r} + (10'd1 << rd_exp);
  assign align_mask = (10'd2 << rd_exp) - 10'd1;
  assign buddy      = rd_free && (rd_exp == s_r);
  assign pair_nxt   = {1'b0, p_r} + (10'd2 << s_r);
  assign mq_nxt     = buddy ? pair_nxt : {1'b0, q_r};
  assign srch_hit   = rd_free && (rd_exp >= e_r) && (!best_valid_r || (rd_exp < best_exp_r));

  // Request size in pages plus header, rounded to a power of two
  assign round_sum = {1'b0, bytes_r} + 22'(PAGE_BYTES - 1);
  assign pages     = 11'(round_sum >> PAGE_SHIFT) + 11'd1;

  always_comb begin
    e_calc = 4'd0;
    for (int i = 10; i >= 0; i--) begin
      if ((12'd1 << i) >= {1'b0, pages}) begin
        e_calc = 4'(i);
      end
    end
  end

  // Status to controller
  always_comb begin
    stat.is_free_op = op_r;
    stat.bytes_zero = (bytes_r == 21'd0);
    stat.unit_zero  = (unit_r == 9'd0);
    stat.too_big    = (e_calc > l_eff);
    stat.step_end   = (step_nxt >= {1'b0, n_pages});
    stat.at_target  = (p_r == target_r);
    stat.rd_free    = rd_free;
    stat.merge_cand = (step_nxt < {1'b0, n_pages}) && rd_free &&
                      (({1'b0, p_r} & align_mask) == 10'd0);
    stat.merge_end  = (mq_nxt >= {1'b0, n_pages});
    stat.best_valid = best_valid_r;
    stat.split_more = (best_exp_r > e_r);
    stat.changed    = changed_r;
  end

  // Store write port and read address
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = p_r[7:0];
    mem_wdata = {l_eff, 1'b1};
    case (cmd.op)
      DP_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = 8'd0;
        mem_wdata = {l_eff, 1'b1};
      end
      DP_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = target_r[7:0];
        mem_wdata = {rd_exp, 1'b1};
      end
      DP_MERGE_Q: begin
        mem_we    = buddy;
        mem_waddr = p_r[7:0];
        mem_wdata = {s_r + 4'd1, 1'b1};
      end
      DP_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = best_r[7:0];
        mem_wdata = (best_exp_r > e_r) ? {best_exp_r - 4'd1, 1'b1} : {e_r, 1'b0};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end
  assign rd_addr = (cmd.op == DP_READ_Q) ? q_r[7:0] : p_r[7:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_log2_r  <= 4'(POOL_PAGES_LOG2);
      exh_r        <= 1'b0;
      best_valid_r <= 1'b0;
      changed_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        pool_log2_r <= cfg_wdata;
        exh_r       <= 1'b0;
      end else if (cmd.set_exh) begin
        exh_r <= 1'b1;
      end
      case (cmd.op)
        DP_DECODE, DP_WALK_START, DP_MARK: begin
          best_valid_r <= 1'b0;
          changed_r    <= 1'b0;
        end
        DP_SRCH_STEP: begin
          if (srch_hit) begin
            best_valid_r <= 1'b1;
          end
        end
        DP_MERGE_Q: begin
          if (buddy) begin
            changed_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      res_status_r <= cmd.res_status;
      res_data_r   <= 9'd0;
    end
    case (cmd.op)
      DP_LATCH: begin
        op_r    <= in_op;
        bytes_r <= in_request_bytes;
        unit_r  <= in_free_unit;
      end
      DP_DECODE: begin
        e_r      <= e_calc;
        target_r <= unit_r - 9'd1;
        p_r      <= 9'd0;
      end
      DP_WALK_START, DP_MARK: begin
        p_r <= 9'd0;
      end
      DP_SRCH_STEP: begin
        if (srch_hit) begin
          best_r     <= p_r;
          best_exp_r <= rd_exp;
        end
        p_r <= step_nxt[8:0];
      end
      DP_FIND_STEP: begin
        if (p_r != target_r) begin
          p_r <= step_nxt[8:0];
        end
      end
      DP_MERGE_P: begin
        q_r <= step_nxt[8:0];
        s_r <= rd_exp;
        if (!stat.merge_cand) begin
          p_r <= step_nxt[8:0];
        end
      end
      DP_MERGE_Q: begin
        p_r <= mq_nxt[8:0];
      end
      DP_SPLIT: begin
        // keep the upper half, lower half stays free
        if (best_exp_r > e_r) begin
          best_r     <= best_r + (9'd1 << (best_exp_r - 4'd1));
          best_exp_r <= best_exp_r - 4'd1;
        end else begin
          res_status_r <= ST_OK;
          res_data_r   <= best_r + 9'd1;
        end
      end
      DP_LOAD_OUT: begin
        out_status_r <= res_status_r;
        out_data_r   <= res_data_r;
        out_exh_r    <= exh_r;
      end
      default: begin
      end
    endcase
  end

  assign out_status         = out_status_r;
  assign out_data_unit      = out_data_r;
  assign out_pool_exhausted = out_exh_r;

endmodule

[rtl/core/bpa_ctrl.sv]
`timescale 1ns / 1ps
module bpa_ctrl import bpa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic     cfg_we,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE,
    S_SR_RD, S_SR_CHK, S_SR_END,
    S_M_RDP, S_M_CHKP, S_M_RDQ, S_M_CHKQ, S_M_END,
    S_F_RD, S_F_CHK, S_MARK,
    S_SPLIT, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   retried_r, retried_nxt;
  logic   after_free_r, after_free_nxt;
  logic   load_out;

  assign in_ready  = (state_r == S_IDLE) && !cfg_we;
  assign out_valid = out_valid_r;
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Next state and datapath command
  always_comb begin
    state_nxt      = state_r;
    retried_nxt    = retried_r;
    after_free_nxt = after_free_r;
    cmd            = '{op: DP_NOP, res_en: 1'b0, res_status: ST_IGNORED, set_exh: 1'b0};
    case (state_r)
      S_INIT: begin
        cmd.op    = DP_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_we) begin
          state_nxt = S_INIT;
        end else if (in_valid) begin
          cmd.op    = DP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.op = DP_DECODE;
        if (stat.is_free_op) begin
          if (stat.unit_zero) begin
            cmd.res_en = 1'b1;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_F_RD;
          end
        end else if (stat.bytes_zero) begin
          cmd.res_en = 1'b1;
          state_nxt  = S_DONE;
        end else if (stat.too_big) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = ST_OOM;
          cmd.set_exh    = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          retried_nxt = 1'b0;
          state_nxt   = S_SR_RD;
        end
      end
      // best-fit search
      S_SR_RD: begin
        state_nxt = S_SR_CHK;
      end
      S_SR_CHK: begin
        cmd.op    = DP_SRCH_STEP;
        state_nxt = stat.step_end ? S_SR_END : S_SR_RD;
      end
      S_SR_END: begin
        if (stat.best_valid) begin
          state_nxt = S_SPLIT;
        end else if (!retried_r) begin
          retried_nxt    = 1'b1;
          after_free_nxt = 1'b0;
          cmd.op         = DP_WALK_START;
          state_nxt      = S_M_RDP;
        end else begin
          cmd.res_en     = 1'b1;
          cmd.res_status = ST_OOM;
          cmd.set_exh    = 1'b1;
          state_nxt      = S_DONE;
        end
      end
      // coalescing passes
      S_M_RDP: begin
        state_nxt = S_M_CHKP;
      end
      S_M_CHKP: begin
        cmd.op = DP_MERGE_P;
        if (stat.merge_cand) begin
          state_nxt = S_M_RDQ;
        end else if (stat.step_end) begin
          state_nxt = S_M_END;
        end else begin
          state_nxt = S_M_RDP;
        end
      end
      S_M_RDQ: begin
        cmd.op    = DP_READ_Q;
        state_nxt = S_M_CHKQ;
      end
      S_M_CHKQ: begin
        cmd.op    = DP_MERGE_Q;
        state_nxt = stat.merge_end ? S_M_END : S_M_RDP;
      end
      S_M_END: begin
        if (stat.changed) begin
          cmd.op    = DP_WALK_START;
          state_nxt = S_M_RDP;
        end else if (after_free_r) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = ST_OK;
          state_nxt      = S_DONE;
        end else begin
          cmd.op    = DP_WALK_START;
          state_nxt = S_SR_RD;
        end
      end
      // locate the block being freed
      S_F_RD: begin
        state_nxt = S_F_CHK;
      end
      S_F_CHK: begin
        cmd.op = DP_FIND_STEP;
        if (stat.at_target) begin
          if (!stat.rd_free) begin
            state_nxt = S_MARK;
          end else begin
            cmd.res_en = 1'b1;
            state_nxt  = S_DONE;
          end
        end else if (stat.step_end) begin
          cmd.res_en = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_F_RD;
        end
      end
      S_MARK: begin
        cmd.op         = DP_MARK;
        after_free_nxt = 1'b1;
        state_nxt      = S_M_RDP;
      end
      S_SPLIT: begin
        cmd.op = DP_SPLIT;
        if (!stat.split_more) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          cmd.op    = DP_LOAD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      out_valid_r  <= 1'b0;
      retried_r    <= 1'b0;
      after_free_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      retried_r    <= retried_nxt;
      after_free_r <= after_free_nxt;
    end
  end

endmodule

[rtl/core/buddy_page_allocator.sv]
// An ignored or oversized word goes straight to the result; any other word walks the block
//   headers, with a buddy test per candidate pair and one split step per halving.
// Words are handled one at a time; the header walks over the header store set the pace,
//   longest when a full coalescing pass precedes a retried search.
// Reset (rst_n, synchronous, active low) and a pool_log2 write while idle lead to S_INIT,
//   which writes the single free block at page 0; no word is accepted in that state.
`timescale 1ns / 1ps
module buddy_page_allocator import bpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [20:0] in_request_bytes,
  input  logic [8:0]  in_free_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [8:0]  out_data_unit,
  output logic        out_pool_exhausted,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpa_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_op              (in_op),
    .in_request_bytes   (in_request_bytes),
    .in_free_unit       (in_free_unit),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_status         (out_status),
    .out_data_unit      (out_data_unit),
    .out_pool_exhausted (out_pool_exhausted)
  );

endmodule

[rtl/core/bpa_checker.sv]
`timescale 1ns / 1ps
module bpa_checker import bpa_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [8:0] out_data_unit,
  input logic       out_pool_exhausted
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_data_unit) && $stable(out_pool_exhausted))
    else $error("result word changed while stalled");

  // only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_OOM) ||
                  (out_status == ST_IGNORED))
    else $error("undefined status code");

  // no data page unless success
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_data_unit == 9'd0)
    else $error("data page on a failed word");

  // failure always reports exhaustion
  a_oom_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OOM) |-> out_pool_exhausted)
    else $error("out of memory without exhausted flag");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_data_unit      (out_data_unit),
  .out_pool_exhausted (out_pool_exhausted)
);
